// ----- src/trr_pkg.sv -----
// ----------------------------------------------------------------------------
// trr_pkg: shared types and codes of the two-list round-robin scheduler
// Opcodes, task status codes and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package trr_pkg;

	localparam int ID_W  = 6;
	localparam int PRI_W = 8;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	// request opcodes
	localparam logic [OP_W-1:0] OP_YIELD  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADMIT  = 2'd1;
	localparam logic [OP_W-1:0] OP_STATUS = 2'd2;
	localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;  // unused, no effect

	// task status codes
	localparam logic [ST_W-1:0] ST_FREE         = 2'd0;
	localparam logic [ST_W-1:0] ST_RUNNABLE     = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_RUNNABLE = 2'd2;
	localparam logic [ST_W-1:0] ST_RSVD         = 2'd3;  // unused, ignored

	// controller to datapath
	typedef struct packed {
		logic clr;        // clear one status/mark entry
		logic cap_in;     // latch request, preset result to none
		logic rd_cur;     // status read at current task
		logic y_keep;     // keep current task, use one slice
		logic push_cur;   // requeue current task, drop it
		logic scan;       // pick queue, read its head
		logic pop;        // pop head, read its status and priority
		logic grant_id;   // grant popped task
		logic push_id;    // requeue popped task
		logic exam_inc;   // count one examination
		logic admit_wr;   // write priority and status of admitted task
		logic admit_push; // append admitted task to queue 0
		logic set_wr;     // write new status
		logic out_load;   // move result to output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic keep_ok;
		logic eff_empty;
		logic st_run;
		logic st_nr;
		logic exams_last;
		logic admit_ok;
		logic out_free;
	} sts_t;

endpackage

// ----- src/trr_ram.sv -----
// ----------------------------------------------------------------------------
// trr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module trr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/trr_ctrl.sv -----
// ----------------------------------------------------------------------------
// trr_ctrl: scheduler controller
// Sequences the clearing pass, yield scan, admit and status requests.
// ----------------------------------------------------------------------------
module trr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    opcode,
	input  trr_pkg::sts_t sts,
	output trr_pkg::cmd_t cmd
);
	import trr_pkg::*;

	typedef enum logic [10:0] {
		S_CLR  = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_Y0   = 11'b00000000100,
		S_Y1   = 11'b00000001000,
		S_SCAN = 11'b00000010000,
		S_POP  = 11'b00000100000,
		S_EXAM = 11'b00001000000,
		S_A0   = 11'b00010000000,
		S_A1   = 11'b00100000000,
		S_SET  = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					case (opcode)
						OP_YIELD:  state_d = S_Y0;
						OP_ADMIT:  state_d = S_A0;
						OP_STATUS: state_d = S_SET;
						default:   state_d = S_DONE;  // unused opcode: no effect
					endcase
				end
			end
			S_Y0: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_Y1;
			end
			S_Y1: begin
				if (sts.keep_ok) begin
					cmd.y_keep = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.push_cur = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = sts.eff_empty ? S_DONE : S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_EXAM;
			end
			S_EXAM: begin
				if (sts.st_run) begin
					cmd.grant_id = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.push_id  = sts.st_nr;
					cmd.exam_inc = 1'b1;
					state_d      = sts.exams_last ? S_DONE : S_SCAN;
				end
			end
			S_A0: begin
				cmd.admit_wr = 1'b1;
				state_d      = S_A1;
			end
			S_A1: begin
				cmd.admit_push = sts.admit_ok;
				state_d        = S_DONE;
			end
			S_SET: begin
				cmd.set_wr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/trr_dp.sv -----
// ----------------------------------------------------------------------------
// trr_dp: scheduler datapath
// Queue storage and pointers, status/priority/mark tables, current task,
// slice count and the result register.
// ----------------------------------------------------------------------------
module trr_dp #(
	parameter int MAX_TASKS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trr_pkg::cmd_t               cmd,
	output trr_pkg::sts_t               sts,
	input  logic [trr_pkg::OP_W-1:0]    opcode,
	input  logic [trr_pkg::ID_W-1:0]    task_id,
	input  logic [trr_pkg::PRI_W-1:0]   priority_req,
	input  logic [trr_pkg::ST_W-1:0]    task_status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        granted,
	output logic [trr_pkg::ID_W-1:0]    chosen_task
);
	import trr_pkg::*;

	localparam int AW     = $clog2(MAX_TASKS);
	localparam int CW     = $clog2(MAX_TASKS + 1);
	localparam int EW     = $clog2(2 * MAX_TASKS + 1);
	localparam int QDEPTH = 2 * (1 << AW);

	function automatic logic id_ok(input logic [ID_W-1:0] id);
		id_ok = ({26'd0, id} < 32'(MAX_TASKS));
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(MAX_TASKS - 1)) ? '0 : p + AW'(1);
	endfunction

	// request and scheduler state
	logic [OP_W-1:0]  op_q;
	logic [ID_W-1:0]  id_q;
	logic [PRI_W-1:0] pri_q;
	logic [ST_W-1:0]  st_q;
	logic             act_q;
	logic             cur_valid_q;
	logic [ID_W-1:0]  cur_id_q;
	logic [PRI_W-1:0] slices_q;
	logic [AW-1:0]    head_q [2];
	logic [AW-1:0]    tail_q [2];
	logic [CW-1:0]    cnt_q  [2];
	logic [EW-1:0]    exams_q;
	logic [AW-1:0]    clr_q;
	logic [ID_W-1:0]  hid_q;
	logic             res_grant_q;
	logic [ID_W-1:0]  res_id_q;
	logic             out_valid_q;
	logic             granted_q;
	logic [ID_W-1:0]  chosen_q;

	// RAM ports
	logic [ID_W-1:0]  q_rdata;
	logic [ST_W-1:0]  st_rdata;
	logic [PRI_W-1:0] pri_rdata;
	logic             mark_rdata;
	logic             st_we, mark_we, q_we;
	logic [AW-1:0]    st_waddr, mark_waddr, st_raddr;
	logic [ST_W-1:0]  st_wdata;
	logic             mark_wdata;
	logic [AW:0]      q_waddr, q_raddr;

	// queue selection
	logic            eff;
	logic            push_en, push_sel, push_do;
	logic [ID_W-1:0] push_val;

	assign eff      = (cnt_q[act_q] == '0) ? ~act_q : act_q;
	assign push_en  = cmd.push_cur | cmd.push_id | cmd.admit_push;
	assign push_sel = cmd.admit_push ? 1'b0 : ~act_q;
	assign push_val = cmd.push_cur ? cur_id_q : (cmd.push_id ? hid_q : id_q);
	assign push_do  = push_en && (!cmd.push_cur || cur_valid_q) &&
	                  (cnt_q[push_sel] != CW'(MAX_TASKS)) && id_ok(push_val);

	// queue RAM: write on push, read head on scan
	assign q_we    = push_do;
	assign q_waddr = {push_sel, tail_q[push_sel]};
	assign q_raddr = {eff, head_q[eff]};

	// status table port muxing
	always_comb begin
		st_we    = 1'b0;
		st_waddr = AW'(id_q);
		st_wdata = ST_RUNNABLE;
		if (cmd.clr) begin
			st_we    = 1'b1;
			st_waddr = clr_q;
			st_wdata = ST_FREE;
		end else if (cmd.admit_wr) begin
			st_we = id_ok(id_q);
		end else if (cmd.set_wr) begin
			st_we    = id_ok(id_q) && (st_q != ST_RSVD);
			st_wdata = st_q;
		end
	end
	assign st_raddr = cmd.rd_cur ? AW'(cur_id_q) : AW'(q_rdata);

	// queued mark port muxing
	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = AW'(push_val);
		mark_wdata = 1'b1;
		if (cmd.clr) begin
			mark_we    = 1'b1;
			mark_waddr = clr_q;
			mark_wdata = 1'b0;
		end else if (cmd.pop) begin
			mark_we    = id_ok(q_rdata);
			mark_waddr = AW'(q_rdata);
			mark_wdata = 1'b0;
		end else if (push_do) begin
			mark_we = 1'b1;
		end
	end

	trr_ram #(.WIDTH(ID_W), .DEPTH(QDEPTH)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(push_val),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	trr_ram #(.WIDTH(ST_W), .DEPTH(MAX_TASKS)) u_status (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	trr_ram #(.WIDTH(PRI_W), .DEPTH(MAX_TASKS)) u_prio (
		.clk(clk), .we(cmd.admit_wr && id_ok(id_q)), .waddr(AW'(id_q)), .wdata(pri_q),
		.raddr(AW'(q_rdata)), .rdata(pri_rdata)
	);

	trr_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_mark (
		.clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
		.raddr(AW'(id_q)), .rdata(mark_rdata)
	);

	// status back to the controller
	assign sts.clr_last   = (clr_q == AW'(MAX_TASKS - 1));
	assign sts.keep_ok    = cur_valid_q && (slices_q != '0) && (st_rdata == ST_RUNNABLE);
	assign sts.eff_empty  = (cnt_q[eff] == '0);
	assign sts.st_run     = id_ok(hid_q) && (st_rdata == ST_RUNNABLE);
	assign sts.st_nr      = id_ok(hid_q) && (st_rdata == ST_NOT_RUNNABLE);
	assign sts.exams_last = (exams_q == EW'(2 * MAX_TASKS - 1));
	assign sts.admit_ok   = id_ok(id_q) && !mark_rdata && !(cur_valid_q && cur_id_q == id_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	// request payload, popped id, result (no reset needed)
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q        <= opcode;
			id_q        <= task_id;
			pri_q       <= priority_req;
			st_q        <= task_status;
			res_grant_q <= 1'b0;
			res_id_q    <= '0;
		end
		if (cmd.pop) begin
			hid_q <= q_rdata;
		end
		if (cmd.y_keep) begin
			res_grant_q <= 1'b1;
			res_id_q    <= cur_id_q;
		end
		if (cmd.grant_id) begin
			res_grant_q <= 1'b1;
			res_id_q    <= hid_q;
		end
		if (cmd.out_load) begin
			granted_q <= res_grant_q;
			chosen_q  <= (op_q == OP_YIELD) ? res_id_q : '0;
		end
		if (cmd.push_cur) begin
			exams_q <= '0;
		end else if (cmd.exam_inc) begin
			exams_q <= exams_q + EW'(1);
		end
	end

	// scheduler control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			cur_valid_q <= 1'b0;
			cur_id_q    <= '0;
			slices_q    <= '0;
			head_q[0]   <= '0;
			head_q[1]   <= '0;
			tail_q[0]   <= '0;
			tail_q[1]   <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.y_keep) begin
				slices_q <= slices_q - PRI_W'(1);
			end
			if (cmd.push_cur) begin
				cur_valid_q <= 1'b0;
				slices_q    <= '0;
			end
			if (cmd.grant_id) begin
				cur_valid_q <= 1'b1;
				cur_id_q    <= hid_q;
				slices_q    <= (pri_rdata == '0) ? '0 : pri_rdata - PRI_W'(1);
			end
			if (push_do) begin
				tail_q[push_sel] <= ptr_inc(tail_q[push_sel]);
				cnt_q[push_sel]  <= cnt_q[push_sel] + CW'(1);
			end
			if (cmd.scan) begin
				act_q <= eff;
			end
			if (cmd.pop) begin
				head_q[act_q] <= ptr_inc(head_q[act_q]);
				cnt_q[act_q]  <= cnt_q[act_q] - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign chosen_task = chosen_q;

endmodule

// ----- src/two_list_round_robin_scheduler.sv -----
// Flow: a yield either keeps its current task or scans the queue heads, examining
//   at most 2*MAX_TASKS heads and none when both queues are empty; admit, set
//   status and the unused opcode do no scan. One request at a time; a result
//   waits while the output register is full until out_ready frees it.
// Reset: asynchronous, active low; a clearing pass then frees every task
//   before the first request is taken.
// ----------------------------------------------------------------------------
// two_list_round_robin_scheduler: time-sliced round robin over two queues
// Controller state machine plus datapath with RAM-based queues and tables.
// ----------------------------------------------------------------------------
module two_list_round_robin_scheduler #(
	parameter int MAX_TASKS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [trr_pkg::OP_W-1:0]  opcode,
	input  logic [trr_pkg::ID_W-1:0]  task_id,
	input  logic [trr_pkg::PRI_W-1:0] priority_req,
	input  logic [trr_pkg::ST_W-1:0]  task_status,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      granted,
	output logic [trr_pkg::ID_W-1:0]  chosen_task
);
	import trr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	trr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .sts(sts), .cmd(cmd)
	);

	trr_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.opcode(opcode), .task_id(task_id), .priority_req(priority_req),
		.task_status(task_status), .out_valid(out_valid), .out_ready(out_ready),
		.granted(granted), .chosen_task(chosen_task)
	);

	// no grant means no task id
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> chosen_task == '0)
		else $error("chosen_task nonzero without grant");

	// queue write port has a single source per cycle
	a_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_cur, cmd.push_id, cmd.admit_push}))
		else $error("two queue pushes in one cycle");

	// an accepted request is worked on, not overtaken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

endmodule
